### hw/rtl/iirtdf2_pkg.sv
// ----------------------------------------------------------------------------
// iirtdf2_pkg
// Shared types, codes and widths of the transposed direct form II IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package iirtdf2_pkg;

	// default number of taps (numerator and denominator coefficients)
	localparam int TAPS_DEFAULT = 9;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int SAMPLE_W = 16;
	localparam int INDEX_W  = 4;
	localparam int COEF_W   = 32;
	localparam int PROD_W   = COEF_W + SAMPLE_W;
	localparam int Z_W      = 48;
	localparam int ACC_W    = Z_W + 1;
	localparam int DIFF_W   = Z_W + 2;
	localparam int FRAC_W   = 24;

	// operation codes
	localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_NUM = 2'd1;
	localparam logic [OP_W-1:0] OP_WR_DEN = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_Y_SUM,
		ST_Y_ROUND,
		ST_TAP_B,
		ST_TAP_A,
		ST_FLUSH
	} state_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic mul_en;   // load product register
		logic mul_fb;   // product is a[i] * y instead of b[i] * x
		logic mul_port; // take x from the input port (accept cycle)
		logic x_load;   // capture the input sample
		logic acc_y;    // acc = product + z[0]
		logic acc_tap;  // acc = product + z[i]
		logic y_round;  // round and saturate the output, load y
		logic z_wr;     // write acc - product into the delay line
	} ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/iirtdf2_coef.sv
// ----------------------------------------------------------------------------
// iirtdf2_coef
// Numerator and denominator coefficient registers with one write port and
// one read tap shared by the multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module iirtdf2_coef #(
	parameter int TAPS = iirtdf2_pkg::TAPS_DEFAULT,
	parameter int CW   = $clog2(TAPS)
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     wr_num,
	input  wire                                     wr_den,
	input  wire  [iirtdf2_pkg::INDEX_W-1:0]         wr_idx,
	input  wire  [iirtdf2_pkg::COEF_W-1:0]          wr_data,
	input  wire  [CW-1:0]                           rd_idx,
	output logic signed [iirtdf2_pkg::COEF_W-1:0]   b_coef,
	output logic signed [iirtdf2_pkg::COEF_W-1:0]   a_coef
);
	import iirtdf2_pkg::*;

	localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

	logic [COEF_W-1:0] b_q [TAPS];
	logic [COEF_W-1:0] a_q [TAPS];
	logic [IW-1:0]     idx_ext;
	logic              idx_ok;

	// writes beyond the last tap are dropped
	assign idx_ext = IW'(wr_idx);
	assign idx_ok  = (32'(wr_idx) < TAPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				b_q[k] <= '0;
				a_q[k] <= '0;
			end
		end else begin
			if (wr_num && idx_ok) begin
				b_q[idx_ext[CW-1:0]] <= wr_data;
			end
			if (wr_den && idx_ok) begin
				a_q[idx_ext[CW-1:0]] <= wr_data;
			end
		end
	end

	// read tap for the multiplier
	assign b_coef = signed'(b_q[rd_idx]);
	assign a_coef = signed'(a_q[rd_idx]);

endmodule

`default_nettype wire

### hw/rtl/iirtdf2_mac.sv
// ----------------------------------------------------------------------------
// iirtdf2_mac
// Shared multiply-accumulate datapath: one 32x16 multiplier, accumulator,
// output rounding and the delay line.
// ----------------------------------------------------------------------------
`default_nettype none

module iirtdf2_mac #(
	parameter int TAPS = iirtdf2_pkg::TAPS_DEFAULT,
	parameter int TW   = $clog2(TAPS),
	parameter int ZW   = (TAPS > 2) ? $clog2(TAPS - 1) : 1
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  iirtdf2_pkg::ctrl_t                      ctrl,
	input  wire                                     feedback_enable,
	input  wire  [TW-1:0]                           tap_idx,
	input  wire  [ZW-1:0]                           z_idx,
	input  wire  [iirtdf2_pkg::SAMPLE_W-1:0]        sample,
	input  wire  signed [iirtdf2_pkg::COEF_W-1:0]   b_coef,
	input  wire  signed [iirtdf2_pkg::COEF_W-1:0]   a_coef,
	output logic [iirtdf2_pkg::SAMPLE_W-1:0]        y_next,
	output logic                                    clip_next
);
	import iirtdf2_pkg::*;

	localparam logic signed [DIFF_W-1:0] RND_HALF  = DIFF_W'(1) << (FRAC_W - 1);
	localparam logic signed [DIFF_W-FRAC_W-1:0] Y_MAX = 26'sd32767;
	localparam logic signed [DIFF_W-FRAC_W-1:0] Y_MIN = -26'sd32768;
	localparam logic signed [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
	localparam logic signed [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] yq_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [Z_W-1:0]      z_q [TAPS-1];

	logic signed [COEF_W-1:0]   mul_a;
	logic signed [SAMPLE_W-1:0] mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [Z_W-1:0]      z_next;
	logic signed [DIFF_W-1:0]   rnd;
	logic signed [DIFF_W-FRAC_W-1:0] yr;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [Z_W-1:0]      z_sat;

	// multiplier operand select
	always_comb begin
		mul_a = ctrl.mul_fb ? a_coef : b_coef;
		if (ctrl.mul_fb) begin
			mul_b = yq_q;
		end else if (ctrl.mul_port) begin
			mul_b = signed'(sample);
		end else begin
			mul_b = x_q;
		end
		mul_p = mul_a * mul_b;
		if (ctrl.mul_fb && !feedback_enable) begin
			mul_p = '0;
		end
	end

	// delay term for the current tap; the last tap sees zero
	always_comb begin
		if (32'(tap_idx) < TAPS - 1) begin
			z_next = z_q[tap_idx[ZW-1:0]];
		end else begin
			z_next = '0;
		end
	end

	// round half up to an integer and saturate to 16 bits
	always_comb begin
		rnd = DIFF_W'(acc_q) + RND_HALF;
		yr  = rnd[DIFF_W-1:FRAC_W];
		if (yr > Y_MAX) begin
			y_next    = 16'h7FFF;
			clip_next = 1'b1;
		end else if (yr < Y_MIN) begin
			y_next    = 16'h8000;
			clip_next = 1'b1;
		end else begin
			y_next    = yr[SAMPLE_W-1:0];
			clip_next = 1'b0;
		end
	end

	// new delay value: acc - feedback product, saturated to 48 bits
	always_comb begin
		diff = DIFF_W'(acc_q) - DIFF_W'(prod_q);
		if (diff[DIFF_W-1] && !(&diff[DIFF_W-2:Z_W-1])) begin
			z_sat = Z_MIN;
		end else if (!diff[DIFF_W-1] && (|diff[DIFF_W-2:Z_W-1])) begin
			z_sat = Z_MAX;
		end else begin
			z_sat = diff[Z_W-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.x_load) begin
			x_q <= signed'(sample);
		end
		if (ctrl.mul_en) begin
			prod_q <= mul_p;
		end
		if (ctrl.acc_y) begin
			acc_q <= ACC_W'(prod_q) + ACC_W'(z_q[0]);
		end else if (ctrl.acc_tap) begin
			acc_q <= ACC_W'(prod_q) + ACC_W'(z_next);
		end
		if (ctrl.y_round) begin
			yq_q <= signed'(y_next);
		end
	end

	// delay line, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS - 1; k++) begin
				z_q[k] <= '0;
			end
		end else if (ctrl.z_wr) begin
			z_q[z_idx] <= z_sat;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/iirtdf2_ctrl.sv
// ----------------------------------------------------------------------------
// iirtdf2_ctrl
// Sequencer: steps the shared multiplier through the output and the taps.
// ----------------------------------------------------------------------------
`default_nettype none

module iirtdf2_ctrl #(
	parameter int TAPS = iirtdf2_pkg::TAPS_DEFAULT,
	parameter int TW   = $clog2(TAPS),
	parameter int ZW   = (TAPS > 2) ? $clog2(TAPS - 1) : 1
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire  [iirtdf2_pkg::OP_W-1:0] op,
	input  wire                          out_free,
	output logic                         in_ready,
	output iirtdf2_pkg::ctrl_t           ctrl,
	output logic [TW-1:0]                tap_idx,
	output logic [ZW-1:0]                z_idx
);
	import iirtdf2_pkg::*;

	state_t        state_q;
	state_t        state_d;
	logic [TW-1:0] tap_q;
	logic [TW-1:0] tap_d;
	logic [TW-1:0] wr_tap;
	logic          start;

	assign start = in_valid && (state_q == ST_IDLE) && (op == OP_FILTER);

	// next state
	always_comb begin
		state_d = state_q;
		tap_d   = tap_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_Y_SUM;
				end
			end
			ST_Y_SUM: begin
				state_d = ST_Y_ROUND;
			end
			ST_Y_ROUND: begin
				if (out_free) begin
					state_d = ST_TAP_B;
					tap_d   = TW'(1);
				end
			end
			ST_TAP_B: begin
				state_d = ST_TAP_A;
			end
			ST_TAP_A: begin
				if (tap_q == TW'(TAPS - 1)) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_TAP_B;
					tap_d   = tap_q + TW'(1);
				end
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
		end
	end

	// outputs
	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		tap_idx  = tap_q;
		wr_tap   = tap_q - TW'(2);
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				tap_idx       = '0;
				ctrl.mul_en   = start;
				ctrl.mul_port = 1'b1;
				ctrl.x_load   = start;
			end
			ST_Y_SUM: begin
				ctrl.acc_y = 1'b1;
			end
			ST_Y_ROUND: begin
				ctrl.y_round = out_free;
			end
			ST_TAP_B: begin
				// finish the previous tap while multiplying b[i] * x
				ctrl.mul_en = 1'b1;
				ctrl.z_wr   = (tap_q != TW'(1));
			end
			ST_TAP_A: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_fb  = 1'b1;
				ctrl.acc_tap = 1'b1;
			end
			ST_FLUSH: begin
				ctrl.z_wr = 1'b1;
				wr_tap    = tap_q - TW'(1);
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	assign z_idx = wr_tap[ZW-1:0];

endmodule

`default_nettype wire

### hw/rtl/iir_filter_transposed_df2_unit.sv
// ----------------------------------------------------------------------------
// iir_filter_transposed_df2_unit
// IIR filter in transposed direct form II with a shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word: op, sample, coeff_index,
//   coeff_value. Op filter runs one sample; op write numerator or write
//   denominator loads a coefficient in the accept cycle and gives no result.
//   Output channel (out_valid/out_ready) carries filtered and clipped.
//   cfg_we/cfg_wdata write feedback_enable (0 drops the feedback term).
// Timing:
//   A sample word passes the product, accumulator and output registers to
//   make its result valid; no new word is taken until the sequencer is idle
//   again, the one 32x16 multiplier doing two products per tap after tap 0.
//   Coefficient writes are taken only while the sequencer is idle.
// Reset:
//   Coefficients and delay line clear to zero, feedback_enable sets to 1.
// Stall:
//   The result sits in an output register; if the previous word is still
//   there when the new output is ready, the sequencer holds until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_filter_transposed_df2_unit #(
	parameter int TAPS = iirtdf2_pkg::TAPS_DEFAULT
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire                                  cfg_wdata,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [iirtdf2_pkg::OP_W-1:0]         op,
	input  wire  [iirtdf2_pkg::SAMPLE_W-1:0]     sample,
	input  wire  [iirtdf2_pkg::INDEX_W-1:0]      coeff_index,
	input  wire  [iirtdf2_pkg::COEF_W-1:0]       coeff_value,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [iirtdf2_pkg::SAMPLE_W-1:0]     filtered,
	output logic                                 clipped
);
	import iirtdf2_pkg::*;

	localparam int TW = $clog2(TAPS);
	localparam int ZW = (TAPS > 2) ? $clog2(TAPS - 1) : 1;

	logic                       feedback_q;
	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        filtered_q;
	logic                       clipped_q;
	logic                       out_free;
	logic                       in_accept;
	ctrl_t                      ctrl;
	logic [TW-1:0]              tap_idx;
	logic [ZW-1:0]              z_idx;
	logic signed [COEF_W-1:0]   b_coef;
	logic signed [COEF_W-1:0]   a_coef;
	logic [SAMPLE_W-1:0]        y_next;
	logic                       clip_next;

	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feedback_q <= 1'b1;
		end else if (cfg_we) begin
			feedback_q <= cfg_wdata;
		end
	end

	iirtdf2_ctrl #(
		.TAPS (TAPS),
		.TW   (TW),
		.ZW   (ZW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl),
		.tap_idx  (tap_idx),
		.z_idx    (z_idx)
	);

	iirtdf2_coef #(
		.TAPS (TAPS),
		.CW   (TW)
	) u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_num  (in_accept && (op == OP_WR_NUM)),
		.wr_den  (in_accept && (op == OP_WR_DEN)),
		.wr_idx  (coeff_index),
		.wr_data (coeff_value),
		.rd_idx  (tap_idx),
		.b_coef  (b_coef),
		.a_coef  (a_coef)
	);

	iirtdf2_mac #(
		.TAPS (TAPS),
		.TW   (TW),
		.ZW   (ZW)
	) u_mac (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.feedback_enable (feedback_q),
		.tap_idx         (tap_idx),
		.z_idx           (z_idx),
		.sample          (sample),
		.b_coef          (b_coef),
		.a_coef          (a_coef),
		.y_next          (y_next),
		.clip_next       (clip_next)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.y_round) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.y_round) begin
			filtered_q <= y_next;
			clipped_q  <= clip_next;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign clipped   = clipped_q;

endmodule

`default_nettype wire
